FILE: rtl/core/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants of the stage cycle profiler
// Beat payloads, command and register codes, and the fixed scale factors.
// ----------------------------------------------------------------------------
package scp_pkg;

  // Commands carried in the command field of an input beat.
  localparam logic [2:0] CMD_END   = 3'd0;
  localparam logic [2:0] CMD_LOAD  = 3'd1;
  localparam logic [2:0] CMD_MAXUS = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_RESET = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_SECOND = 2'd2;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [31:0] CLOCK_HZ_RST    = 32'd480000000;
  localparam logic [3:0]  LOAD_FIRST_RST  = 4'd0;
  localparam logic [3:0]  LOAD_SECOND_RST = 4'd8;

  // Scale factors and the percent cap.
  localparam logic [6:0]  PCT_SCALE  = 7'd100;
  localparam logic [63:0] PCT_CAP    = 64'd100;
  localparam logic [19:0] USEC_SCALE = 20'd1000000;

  // The divider retires one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = 64;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  stage;
    logic [31:0] start_stamp;
    logic [31:0] now_stamp;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [31:0] call_count;
    logic [31:0] max_cycles;
    logic        status;
  } out_item_t;

  // One stage's counters as held in the counter RAM.
  typedef struct packed {
    logic [63:0] total;
    logic [31:0] calls;
    logic [31:0] peak;
  } entry_t;

endpackage

FILE: rtl/core/scp_ram.sv
// ----------------------------------------------------------------------------
// scp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents have no reset.
// ----------------------------------------------------------------------------
module scp_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 9,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/stage_cycle_profiler_top.sv
// ----------------------------------------------------------------------------
// stage_cycle_profiler_top: per-stage cycle profiler with event counters
// Each input beat carries one command and produces exactly one result beat.
// An end command adds the elapsed time (now minus start, modulo 2^32) to the
// stage's 64-bit total, counts the call, tracks the stage maximum and feeds the
// load window when the stage is one of the two load stages. A load command
// returns the busy share of the window in percent (capped at 100, 0 for an
// empty window) and restarts the window; a max command returns the summed peaks
// of the two load stages in microseconds; a read command returns one stage's
// counters; a reset command clears the counters and the load window. The block
// works on one beat at a time and holds in_stall_o high until the result has
// been loaded into the output register, which then waits for the consumer while
// the next beat is taken. End and read results wait on one registered counter
// RAM read. Load and max results (for a non-empty window or nonzero clock rate)
// come from the shared 64-step bit-serial restoring divider, which retires one
// quotient bit per cycle; max adds two RAM reads and a register stage for the
// microsecond scaling. Counter reset is immediate: a valid bit per stage marks
// which RAM entries hold data, so there is no clearing pass.
// ----------------------------------------------------------------------------
module stage_cycle_profiler_top #(
  parameter int STAGE_COUNT = 9
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [scp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [scp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // Command channel.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  scp_pkg::in_item_t                    in_data_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output scp_pkg::out_item_t                   out_data_o
);

  import scp_pkg::*;

  // Address width of the counter RAM, and a width that can hold both any
  // 4-bit stage field and the stage count for range checks.
  localparam int AW     = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
  localparam int XW     = AW + 4;
  localparam int VN     = 1 << AW;
  localparam int CNT_W  = $clog2(DIV_STEPS);
  localparam int EW     = $bits(entry_t);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MX2  = 3'd2;
  localparam logic [2:0] S_MX3  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // Control state, set to its reset values by reset.
  logic [2:0]    state_q, state_d;
  logic [31:0]   clk_hz_q, clk_hz_d;
  logic [3:0]    first_q, first_d;
  logic [3:0]    second_q, second_d;
  logic [31:0]   busy_q, busy_d;
  logic [31:0]   wstart_q, wstart_d;
  logic [VN-1:0] vld_q, vld_d;
  logic          out_valid_q, out_valid_d;

  // Working payload registers.
  logic [3:0]       stage_q, stage_d;
  logic             is_end_q, is_end_d;
  logic             div_load_q, div_load_d;
  logic [31:0]      elap_q, elap_d;
  logic [31:0]      peak1_q, peak1_d;
  logic [32:0]      cyc_q, cyc_d;
  logic [63:0]      div_n_q, div_n_d;
  logic [31:0]      div_r_q, div_r_d;
  logic [31:0]      div_d_q, div_d_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  out_item_t        res_q, res_d;
  out_item_t        out_q, out_d;

  // Combinational helpers.
  logic          in_accept;
  logic [XW-1:0] in_stage_x, stage_x, first_x, second_x;
  logic          in_stage_ok, first_ok, second_ok;
  logic [AW-1:0] stage_addr, first_addr, second_addr;
  logic [31:0]   window;
  logic [38:0]   busy_x100;
  logic [52:0]   usec_prod;
  logic [32:0]   rem_sh;
  logic          q_bit;
  logic [63:0]   quot;
  logic          load_hit;

  // Counter RAM port signals.
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata, ram_wdata, cur_entry;
  logic [EW-1:0] ram_rdata_raw;

  assign in_accept = in_valid_i && !in_stall_o;

  assign in_stage_x  = XW'(in_data_i.stage);
  assign stage_x     = XW'(stage_q);
  assign first_x     = XW'(first_q);
  assign second_x    = XW'(second_q);
  assign in_stage_ok = in_stage_x < XW'(STAGE_COUNT);
  assign first_ok    = first_x < XW'(STAGE_COUNT);
  assign second_ok   = second_x < XW'(STAGE_COUNT);
  assign stage_addr  = stage_x[AW-1:0];
  assign first_addr  = first_x[AW-1:0];
  assign second_addr = second_x[AW-1:0];

  assign window    = in_data_i.now_stamp - wstart_q;
  assign busy_x100 = 39'(busy_q) * 39'(PCT_SCALE);
  assign usec_prod = 53'(cyc_q) * 53'(USEC_SCALE);

  // One restoring division step: shift in the next dividend bit and subtract
  // the divisor when it fits. The quotient bit shifts into the dividend word.
  assign rem_sh = {div_r_q, div_n_q[63]};
  assign q_bit  = rem_sh >= {1'b0, div_d_q};
  assign quot   = {div_n_q[62:0], q_bit};

  // The read address is chosen while idle for the arriving beat, and in the
  // S_MX2 state for the second load stage.
  always_comb begin
    if (state_q == S_MX2) begin
      ram_raddr = second_addr;
    end else if (in_data_i.command == CMD_MAXUS) begin
      ram_raddr = first_addr;
    end else begin
      ram_raddr = in_stage_x[AW-1:0];
    end
  end

  assign ram_rdata = entry_t'(ram_rdata_raw);
  assign cur_entry = vld_q[stage_addr] ? ram_rdata : '0;
  assign load_hit  = (stage_q == first_q) || (stage_q == second_q);

  always_comb begin
    ram_wdata       = cur_entry;
    ram_wdata.total = cur_entry.total + 64'(elap_q);
    ram_wdata.calls = cur_entry.calls + 32'd1;
    ram_wdata.peak  = (elap_q > cur_entry.peak) ? elap_q : cur_entry.peak;
  end

  assign ram_we = (state_q == S_RD) && is_end_q;

  scp_ram #(
    .WIDTH (EW),
    .DEPTH (STAGE_COUNT)
  ) u_scp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (stage_addr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  always_comb begin
    state_d     = state_q;
    clk_hz_d    = clk_hz_q;
    first_d     = first_q;
    second_d    = second_q;
    busy_d      = busy_q;
    wstart_d    = wstart_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q && out_stall_i;
    stage_d     = stage_q;
    is_end_d    = is_end_q;
    div_load_d  = div_load_q;
    elap_d      = elap_q;
    peak1_d     = peak1_q;
    cyc_d       = cyc_q;
    div_n_d     = div_n_q;
    div_r_d     = div_r_q;
    div_d_d     = div_d_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_d       = out_q;

    // The user writes configuration only while idle; the block has no check.
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CLOCK_HZ:    clk_hz_d = cfg_data_i;
        CFG_LOAD_FIRST:  first_d  = cfg_data_i[3:0];
        CFG_LOAD_SECOND: second_d = cfg_data_i[3:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_d   = '0;
          state_d = S_DONE;
          case (in_data_i.command)
            CMD_END, CMD_READ: begin
              if (!in_stage_ok) begin
                res_d.status = 1'b1;
              end else begin
                stage_d  = in_data_i.stage;
                is_end_d = in_data_i.command == CMD_END;
                elap_d   = in_data_i.now_stamp - in_data_i.start_stamp;
                state_d  = S_RD;
              end
            end
            CMD_LOAD: begin
              busy_d   = '0;
              wstart_d = in_data_i.now_stamp;
              if (window != '0) begin
                div_n_d    = 64'(busy_x100);
                div_d_d    = window;
                div_r_d    = '0;
                cnt_d      = '0;
                div_load_d = 1'b1;
                state_d    = S_DIV;
              end
            end
            CMD_MAXUS: begin
              if (clk_hz_q != '0) begin
                div_load_d = 1'b0;
                state_d    = S_MX2;
              end
            end
            CMD_RESET: begin
              vld_d    = '0;
              busy_d   = '0;
              wstart_d = in_data_i.now_stamp;
            end
            default: ;
          endcase
        end
      end

      S_RD: begin
        res_d = '0;
        if (is_end_q) begin
          vld_d[stage_addr] = 1'b1;
          if (load_hit) begin
            busy_d = busy_q + elap_q;
          end
          res_d.value      = ram_wdata.total;
          res_d.call_count = ram_wdata.calls;
          res_d.max_cycles = ram_wdata.peak;
        end else begin
          res_d.value      = cur_entry.total;
          res_d.call_count = cur_entry.calls;
          res_d.max_cycles = cur_entry.peak;
        end
        state_d = S_DONE;
      end

      S_MX2: begin
        peak1_d = (first_ok && vld_q[first_addr]) ? ram_rdata.peak : '0;
        state_d = S_MX3;
      end

      S_MX3: begin
        if (second_ok && vld_q[second_addr]) begin
          cyc_d = {1'b0, peak1_q} + {1'b0, ram_rdata.peak};
        end else begin
          cyc_d = {1'b0, peak1_q};
        end
        state_d = S_MUL;
      end

      S_MUL: begin
        div_n_d = 64'(usec_prod);
        div_d_d = clk_hz_q;
        div_r_d = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end

      S_DIV: begin
        div_n_d = quot;
        div_r_d = q_bit ? 32'(rem_sh - {1'b0, div_d_q}) : rem_sh[31:0];
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          res_d = '0;
          if (div_load_q && (quot > PCT_CAP)) begin
            res_d.value = PCT_CAP;
          end else begin
            res_d.value = quot;
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // Hand the result over as soon as the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clk_hz_q    <= CLOCK_HZ_RST;
      first_q     <= LOAD_FIRST_RST;
      second_q    <= LOAD_SECOND_RST;
      busy_q      <= '0;
      wstart_q    <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clk_hz_q    <= clk_hz_d;
      first_q     <= first_d;
      second_q    <= second_d;
      busy_q      <= busy_d;
      wstart_q    <= wstart_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q    <= stage_d;
    is_end_q   <= is_end_d;
    div_load_q <= div_load_d;
    elap_q     <= elap_d;
    peak1_q    <= peak1_d;
    cyc_q      <= cyc_d;
    div_n_q    <= div_n_d;
    div_r_q    <= div_r_d;
    div_d_q    <= div_d_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/core/scp_checker.sv
// ----------------------------------------------------------------------------
// scp_checker: port-level assertions for the stage cycle profiler
// Watches the command and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module scp_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  scp_pkg::out_item_t out_data_o
);

  import scp_pkg::*;

  // A stalled result beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // The block works on one command at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second command taken while one is in progress");

  // An ignored stage reports nothing but the flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |->
      (out_data_o.value == '0) && (out_data_o.call_count == '0) &&
      (out_data_o.max_cycles == '0))
    else $error("invalid stage result carries counter data");

endmodule

bind stage_cycle_profiler_top scp_checker u_scp_checker (.*);
